[design/knps_pkg.sv]
package knps_pkg;

    localparam int COORD_FIELDS  = 4;
    localparam int COORD_W       = 16;
    localparam int POINT_W       = COORD_FIELDS * COORD_W;
    localparam int DIST_W        = 34;
    localparam int SQ_W          = 32;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int MAX_DIMS      = 4;
    localparam int MAX_NEIGHBORS = 16;
    localparam int DIM_BOUND     = (MAX_DIMS < COORD_FIELDS) ? MAX_DIMS : COORD_FIELDS;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 5;
    localparam int DIMS_W      = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_X0       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_X1       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_X2       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_X3       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOR_COUNT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_DIMS    = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd8;
    localparam logic [DIMS_W-1:0]  DIMS_RESET  = 3'd4;

    localparam int OUT_DATA_W = ((POINT_W + DIST_W + 7) / 8) * 8;

    // A scored point leaving the distance pipeline.
    typedef struct packed {
        logic                valid;
        logic                final_point;
        logic [DIST_W-1:0]   distance;
        logic [POINT_W-1:0]  coord;
    } knps_item_t;

    // What a cell shows to its right-hand neighbour.
    typedef struct packed {
        logic                valid;
        logic                gt;
        logic [DIST_W-1:0]   distance;
        logic [POINT_W-1:0]  coord;
    } knps_link_t;

    // One entry of the output row.
    typedef struct packed {
        logic                valid;
        logic [DIST_W-1:0]   distance;
        logic [POINT_W-1:0]  coord;
    } knps_entry_t;

    function automatic logic [DIMS_W-1:0] limit_dims(input logic [DIMS_W-1:0] d);
        logic [DIMS_W-1:0] r;
        r = d;
        if (r == '0) begin
            r = DIMS_W'(1);
        end
        if (r > DIMS_W'(DIM_BOUND)) begin
            r = DIMS_W'(DIM_BOUND);
        end
        return r;
    endfunction

endpackage

[design/knps_dist.sv]
module knps_dist (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   advance,
    input  logic                                                   in_valid,
    input  logic                                                   in_final,
    input  logic [knps_pkg::POINT_W-1:0]                           in_coord,
    input  logic [knps_pkg::POINT_W-1:0]                           query,
    input  logic [knps_pkg::DIMS_W-1:0]                            active_dims,
    output knps_pkg::knps_item_t                                   out_item
);

    localparam int NF = knps_pkg::COORD_FIELDS;
    localparam int CW = knps_pkg::COORD_W;

    logic [knps_pkg::DIMS_W-1:0] dims;

    logic                               a_valid_reg, a_valid_next;
    logic                               a_final_reg;
    logic [knps_pkg::POINT_W-1:0]       a_coord_reg;
    logic signed [knps_pkg::DIFF_W-1:0] a_diff_reg  [NF];
    logic signed [knps_pkg::DIFF_W-1:0] a_diff_next [NF];

    logic                               b_valid_reg;
    logic                               b_final_reg;
    logic [knps_pkg::POINT_W-1:0]       b_coord_reg;
    logic [knps_pkg::SQ_W-1:0]          b_sq_reg  [NF];
    logic [knps_pkg::SQ_W-1:0]          b_sq_next [NF];
    logic signed [2*knps_pkg::DIFF_W-1:0] prod    [NF];

    logic                               c_valid_reg;
    logic                               c_final_reg;
    logic [knps_pkg::POINT_W-1:0]       c_coord_reg;
    logic [knps_pkg::DIST_W-1:0]        c_dist_reg, c_dist_next;

    assign dims = knps_pkg::limit_dims(active_dims);
    assign a_valid_next = in_valid;

    always_comb begin
        for (int j = 0; j < NF; j++) begin
            if (knps_pkg::DIMS_W'(j) < dims) begin
                a_diff_next[j] = $signed({in_coord[CW*j+CW-1], in_coord[CW*j +: CW]})
                               - $signed({query[CW*j+CW-1], query[CW*j +: CW]});
            end else begin
                a_diff_next[j] = '0;
            end
            prod[j]      = a_diff_reg[j] * a_diff_reg[j];
            b_sq_next[j] = prod[j][knps_pkg::SQ_W-1:0];
        end
        c_dist_next = '0;
        for (int j = 0; j < NF; j++) begin
            c_dist_next = c_dist_next + knps_pkg::DIST_W'(b_sq_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_final_reg <= in_final;
            a_coord_reg <= in_coord;
            a_diff_reg  <= a_diff_next;
            b_final_reg <= a_final_reg;
            b_coord_reg <= a_coord_reg;
            b_sq_reg    <= b_sq_next;
            c_final_reg <= b_final_reg;
            c_coord_reg <= b_coord_reg;
            c_dist_reg  <= c_dist_next;
        end
    end

    assign out_item.valid       = c_valid_reg;
    assign out_item.final_point = c_final_reg;
    assign out_item.distance    = c_dist_reg;
    assign out_item.coord       = c_coord_reg;

endmodule

[design/knps_cell.sv]
module knps_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              update,
    input  logic                              final_point,
    input  logic                              grow,
    input  logic [knps_pkg::DIST_W-1:0]       new_dist,
    input  logic [knps_pkg::POINT_W-1:0]      new_coord,
    input  knps_pkg::knps_link_t              left,
    output knps_pkg::knps_link_t              right,
    input  logic                              drain_shift,
    input  knps_pkg::knps_entry_t             drain_in,
    output knps_pkg::knps_entry_t             drain_out
);

    logic                          valid_reg, valid_next;
    logic [knps_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic [knps_pkg::POINT_W-1:0]  coord_reg, coord_next;
    logic                          drain_valid_reg;
    logic [knps_pkg::DIST_W-1:0]   drain_dist_reg;
    logic [knps_pkg::POINT_W-1:0]  drain_coord_reg;
    logic                          gt;
    logic                          tail;
    logic                          take;

    // Cells hold a sorted prefix; the one just past it is the tail.
    assign gt   = valid_reg && (dist_reg > new_dist);
    assign tail = !valid_reg && left.valid;
    assign take = gt || (grow && tail);

    always_comb begin
        valid_next = valid_reg || (grow && tail);
        dist_next  = dist_reg;
        coord_next = coord_reg;
        if (take) begin
            if (left.gt) begin
                dist_next  = left.distance;
                coord_next = left.coord;
            end else begin
                dist_next  = new_dist;
                coord_next = new_coord;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            drain_valid_reg <= 1'b0;
        end else begin
            if (update) begin
                valid_reg <= final_point ? 1'b0 : valid_next;
            end
            if (update && final_point) begin
                drain_valid_reg <= valid_next;
            end else if (drain_shift) begin
                drain_valid_reg <= drain_in.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            dist_reg  <= dist_next;
            coord_reg <= coord_next;
        end
        if (update && final_point) begin
            drain_dist_reg  <= dist_next;
            drain_coord_reg <= coord_next;
        end else if (drain_shift) begin
            drain_dist_reg  <= drain_in.distance;
            drain_coord_reg <= drain_in.coord;
        end
    end

    assign right.valid        = valid_reg;
    assign right.gt           = gt;
    assign right.distance     = dist_reg;
    assign right.coord        = coord_reg;
    assign drain_out.valid    = drain_valid_reg;
    assign drain_out.distance = drain_dist_reg;
    assign drain_out.coord    = drain_coord_reg;

endmodule

[design/k_nearest_point_scan_top.sv]
// Channel | Direction | Contents
// s_      | in        | tdata: coord_0..coord_3, tlast: final_point
// m_      | out       | tdata: out_coord_0..3, sq_distance, tlast: run_end
// cfg_    | in        | cfg_index selects the register, cfg_data carries its value
//
// One point per cycle enters while s_tready is high; the distance pipeline is three stages
// deep, and the cell chain then registers each point into its sorted place.
// On a final point the kept list, with that point sorted in, moves into the output row and
// leaves at one transaction per cycle while m_tready is high, nearest first.
// A second final point waits at the chain while the output row is still busy.
// Sync reset clears list, output row and query, presets count and dims, and holds both readies low.
module k_nearest_point_scan_top #(
    parameter int MAX_NEIGHBORS = knps_pkg::MAX_NEIGHBORS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [knps_pkg::POINT_W-1:0]          s_tdata,  // coord_0..coord_3
    input  logic                                  s_tlast,  // final_point
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [knps_pkg::OUT_DATA_W-1:0]       m_tdata,  // out_coord_0..3, sq_distance, 0
    output logic                                  m_tlast,  // run_end
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [knps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [knps_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int TW = $clog2(MAX_NEIGHBORS + 1);
    localparam int CW = (TW > knps_pkg::COUNT_W) ? TW : knps_pkg::COUNT_W;
    localparam int QW = knps_pkg::COORD_W;

    logic [knps_pkg::POINT_W-1:0]  query_reg;
    logic [knps_pkg::COUNT_W-1:0]  neighbor_count_reg;
    logic [knps_pkg::DIMS_W-1:0]   active_dims_reg;
    logic [TW-1:0]                 kept_total_reg, kept_total_next;
    logic [CW-1:0]                 count_ext;
    logic [CW-1:0]                 count_lim;

    knps_pkg::knps_item_t          item;
    knps_pkg::knps_link_t          links  [MAX_NEIGHBORS+1];
    knps_pkg::knps_entry_t         drains [MAX_NEIGHBORS+1];

    logic stall;
    logic advance;
    logic update;
    logic grow;
    logic drain_shift;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_reg          <= '0;
            neighbor_count_reg <= knps_pkg::COUNT_RESET;
            active_dims_reg    <= knps_pkg::DIMS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                knps_pkg::REG_QUERY_X0:       query_reg[0*QW +: QW] <= cfg_data;
                knps_pkg::REG_QUERY_X1:       query_reg[1*QW +: QW] <= cfg_data;
                knps_pkg::REG_QUERY_X2:       query_reg[2*QW +: QW] <= cfg_data;
                knps_pkg::REG_QUERY_X3:       query_reg[3*QW +: QW] <= cfg_data;
                knps_pkg::REG_NEIGHBOR_COUNT:
                    neighbor_count_reg <= cfg_data[knps_pkg::COUNT_W-1:0];
                knps_pkg::REG_ACTIVE_DIMS:
                    active_dims_reg <= cfg_data[knps_pkg::DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        count_ext = CW'(neighbor_count_reg);
        if (count_ext == '0) begin
            count_lim = CW'(1);
        end else if (count_ext > CW'(MAX_NEIGHBORS)) begin
            count_lim = CW'(MAX_NEIGHBORS);
        end else begin
            count_lim = count_ext;
        end
    end

    assign stall    = item.valid && item.final_point && drains[0].valid;
    assign advance  = !stall;
    assign s_tready = advance && aresetn;
    assign update   = item.valid && !stall;
    assign grow     = CW'(kept_total_reg) < count_lim;

    knps_dist u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (s_tvalid),
        .in_final    (s_tlast),
        .in_coord    (s_tdata),
        .query       (query_reg),
        .active_dims (active_dims_reg),
        .out_item    (item)
    );

    always_comb begin
        kept_total_next = kept_total_reg;
        if (update) begin
            if (item.final_point) begin
                kept_total_next = '0;
            end else if (grow) begin
                kept_total_next = kept_total_reg + TW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_total_reg <= '0;
        end else begin
            kept_total_reg <= kept_total_next;
        end
    end

    assign links[0].valid     = 1'b1;
    assign links[0].gt        = 1'b0;
    assign links[0].distance  = '0;
    assign links[0].coord     = '0;
    assign drains[MAX_NEIGHBORS].valid    = 1'b0;
    assign drains[MAX_NEIGHBORS].distance = '0;
    assign drains[MAX_NEIGHBORS].coord    = '0;

    assign drain_shift = m_tvalid && m_tready;

    for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
        knps_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .update      (update),
            .final_point (item.final_point),
            .grow        (grow),
            .new_dist    (item.distance),
            .new_coord   (item.coord),
            .left        (links[i]),
            .right       (links[i+1]),
            .drain_shift (drain_shift),
            .drain_in    (drains[i+1]),
            .drain_out   (drains[i])
        );
    end

    assign m_tvalid = drains[0].valid;
    assign m_tdata  = knps_pkg::OUT_DATA_W'({drains[0].distance, drains[0].coord});
    assign m_tlast  = !drains[1].valid;

endmodule
